// ===== rtl/core/omv_pkg.sv =====
package omv_pkg;

   // parse phases of one message
   typedef enum logic [2:0] {
      PH_PATH_FIRST,
      PH_PATH,
      PH_PATH_PAD,
      PH_FMT_FIRST,
      PH_FMT,
      PH_STRING,
      PH_COUNT,
      PH_BLOB_HEAD
   } phase_type;

   // argument classes that occupy bytes; T F N I take none and are never stored
   typedef enum logic [1:0] {
      CL_FOUR,
      CL_EIGHT,
      CL_STR,
      CL_BLOB
   } class_type;

   typedef struct packed {
      logic      known;
      logic      sized;
      class_type cls;
   } tag_info_type;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] PRINT_LOW  = 8'h21;
   localparam logic [7:0] PRINT_HIGH = 8'h7E;

   localparam logic [7:0] TAG_INT32   = 8'h69; // i
   localparam logic [7:0] TAG_FLOAT   = 8'h66; // f
   localparam logic [7:0] TAG_MIDI    = 8'h6D; // m
   localparam logic [7:0] TAG_CHAR    = 8'h63; // c
   localparam logic [7:0] TAG_INT64   = 8'h68; // h
   localparam logic [7:0] TAG_DOUBLE  = 8'h64; // d
   localparam logic [7:0] TAG_TIME    = 8'h74; // t
   localparam logic [7:0] TAG_STRING  = 8'h73; // s
   localparam logic [7:0] TAG_SYMBOL  = 8'h53; // S
   localparam logic [7:0] TAG_BLOB    = 8'h62; // b
   localparam logic [7:0] TAG_TRUE    = 8'h54; // T
   localparam logic [7:0] TAG_FALSE   = 8'h46; // F
   localparam logic [7:0] TAG_NIL     = 8'h4E; // N
   localparam logic [7:0] TAG_IMPULSE = 8'h49; // I

   function automatic tag_info_type tag_info(input logic [7:0] c);
      tag_info_type r;
      r = '{known: 1'b0, sized: 1'b0, cls: CL_FOUR};
      case (c) inside
         TAG_INT32, TAG_FLOAT, TAG_MIDI, TAG_CHAR: begin
            r = '{known: 1'b1, sized: 1'b1, cls: CL_FOUR};
         end
         TAG_INT64, TAG_DOUBLE, TAG_TIME: begin
            r = '{known: 1'b1, sized: 1'b1, cls: CL_EIGHT};
         end
         TAG_STRING, TAG_SYMBOL: begin
            r = '{known: 1'b1, sized: 1'b1, cls: CL_STR};
         end
         TAG_BLOB: begin
            r = '{known: 1'b1, sized: 1'b1, cls: CL_BLOB};
         end
         TAG_TRUE, TAG_FALSE, TAG_NIL, TAG_IMPULSE: begin
            r = '{known: 1'b1, sized: 1'b0, cls: CL_FOUR};
         end
         default: begin
            r = '{known: 1'b0, sized: 1'b0, cls: CL_FOUR};
         end
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/omv_ram.sv =====
module omv_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [ADDR_W-1:0]        rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

// ===== rtl/core/omv_parser.sv =====
module omv_parser #(
   parameter int MAX_TYPES = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       end_of_message,
   output logic       message_ok
);

   localparam int CNT_W  = $clog2(MAX_TYPES + 1);
   localparam int ADDR_W = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;

   omv_pkg::phase_type phase_ff, phase_in;
   logic [1:0]         align_ff, align_in;
   logic [CNT_W-1:0]   tag_count_ff, tag_count_in;
   logic [CNT_W-1:0]   sized_count_ff, sized_count_in;
   logic [CNT_W-1:0]   tag_index_ff, tag_index_in;
   logic [31:0]        bytes_left_ff, bytes_left_in;
   logic [31:0]        blob_shift_ff, blob_shift_in;
   logic               error_ff, error_in;
   omv_pkg::class_type first_class_ff, first_class_in;

   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [1:0]            wr_data;
   logic [1:0]            rd_data;
   logic                  do_next;
   logic [1:0]            pad;
   omv_pkg::tag_info_type info;
   omv_pkg::class_type    next_class;

   // compacted list of the tags that occupy argument bytes
   omv_ram #(
      .WIDTH (2),
      .DEPTH (MAX_TYPES)
   ) u_tags (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (tag_index_in[ADDR_W-1:0]),
      .rd_data_ff (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= omv_pkg::PH_PATH_FIRST;
         align_ff       <= '0;
         tag_count_ff   <= '0;
         sized_count_ff <= '0;
         tag_index_ff   <= '0;
         bytes_left_ff  <= '0;
         blob_shift_ff  <= '0;
         error_ff       <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         align_ff       <= align_in;
         tag_count_ff   <= tag_count_in;
         sized_count_ff <= sized_count_in;
         tag_index_ff   <= tag_index_in;
         bytes_left_ff  <= bytes_left_in;
         blob_shift_ff  <= blob_shift_in;
         error_ff       <= error_in;
      end
      first_class_ff <= first_class_in;
   end

   always_comb begin
      phase_in       = phase_ff;
      align_in       = align_ff;
      tag_count_in   = tag_count_ff;
      sized_count_in = sized_count_ff;
      tag_index_in   = tag_index_ff;
      bytes_left_in  = bytes_left_ff;
      blob_shift_in  = blob_shift_ff;
      error_in       = error_ff;
      first_class_in = first_class_ff;
      wr_en          = 1'b0;
      wr_addr        = sized_count_ff[ADDR_W-1:0];
      wr_data        = '0;
      do_next        = 1'b0;
      info           = omv_pkg::tag_info(data_byte);
      // the ram read lags one item, so the first entry comes from a register
      next_class     = (tag_index_ff == '0) ? first_class_ff : omv_pkg::class_type'(rd_data);
      message_ok     = 1'b0;
      pad            = 2'd0 - (align_ff + 2'd1);

      if (step) begin
         align_in = align_ff + 2'd1;
         if (!error_ff) begin
            unique case (phase_ff)
               omv_pkg::PH_PATH_FIRST: begin
                  if (data_byte != omv_pkg::CHAR_SLASH) begin
                     error_in = 1'b1;
                  end else begin
                     phase_in = omv_pkg::PH_PATH;
                  end
               end
               omv_pkg::PH_PATH: begin
                  if (data_byte == omv_pkg::CHAR_NUL) begin
                     phase_in = (align_in == 2'd0) ? omv_pkg::PH_FMT_FIRST
                                                   : omv_pkg::PH_PATH_PAD;
                  end else if (data_byte < omv_pkg::PRINT_LOW ||
                               data_byte > omv_pkg::PRINT_HIGH ||
                               data_byte == omv_pkg::CHAR_HASH) begin
                     error_in = 1'b1;
                  end
               end
               omv_pkg::PH_PATH_PAD: begin
                  if (align_in == 2'd0) begin
                     phase_in = omv_pkg::PH_FMT_FIRST;
                  end
               end
               omv_pkg::PH_FMT_FIRST: begin
                  if (data_byte != omv_pkg::CHAR_COMMA) begin
                     error_in = 1'b1;
                  end else begin
                     phase_in       = omv_pkg::PH_FMT;
                     tag_count_in   = '0;
                     sized_count_in = '0;
                  end
               end
               omv_pkg::PH_FMT: begin
                  if (data_byte == omv_pkg::CHAR_NUL) begin
                     tag_index_in  = '0;
                     phase_in      = omv_pkg::PH_COUNT;
                     bytes_left_in = {30'd0, pad};
                     do_next       = (pad == 2'd0);
                  end else if (!info.known || tag_count_ff >= CNT_W'(MAX_TYPES)) begin
                     error_in = 1'b1;
                  end else begin
                     tag_count_in = tag_count_ff + 1'b1;
                     if (info.sized) begin
                        wr_en          = 1'b1;
                        wr_data        = info.cls;
                        sized_count_in = sized_count_ff + 1'b1;
                        if (sized_count_ff == '0) begin
                           first_class_in = info.cls;
                        end
                     end
                  end
               end
               omv_pkg::PH_STRING: begin
                  if (data_byte == omv_pkg::CHAR_NUL) begin
                     phase_in      = omv_pkg::PH_COUNT;
                     bytes_left_in = {30'd0, pad};
                     do_next       = (pad == 2'd0);
                  end
               end
               omv_pkg::PH_BLOB_HEAD: begin
                  blob_shift_in = {blob_shift_ff[23:0], data_byte};
                  if (align_in == 2'd0) begin
                     if (blob_shift_in[31]) begin
                        error_in = 1'b1;
                     end else begin
                        bytes_left_in = (blob_shift_in + 32'd3) & ~32'd3;
                        phase_in      = omv_pkg::PH_COUNT;
                        do_next       = (bytes_left_in == '0);
                     end
                  end
               end
               omv_pkg::PH_COUNT: begin
                  if (bytes_left_ff == '0) begin
                     error_in = 1'b1;
                  end else begin
                     bytes_left_in = bytes_left_ff - 32'd1;
                     do_next       = (bytes_left_in == '0);
                  end
               end
               default: begin
                  error_in = 1'b1;
               end
            endcase

            // start the next argument that occupies bytes, or finish
            if (do_next) begin
               if (tag_index_in < sized_count_in) begin
                  tag_index_in = tag_index_in + 1'b1;
                  unique case (next_class)
                     omv_pkg::CL_FOUR: begin
                        phase_in      = omv_pkg::PH_COUNT;
                        bytes_left_in = 32'd4;
                     end
                     omv_pkg::CL_EIGHT: begin
                        phase_in      = omv_pkg::PH_COUNT;
                        bytes_left_in = 32'd8;
                     end
                     omv_pkg::CL_STR: begin
                        phase_in = omv_pkg::PH_STRING;
                     end
                     omv_pkg::CL_BLOB: begin
                        phase_in      = omv_pkg::PH_BLOB_HEAD;
                        blob_shift_in = '0;
                     end
                     default: begin
                        phase_in = omv_pkg::PH_STRING;
                     end
                  endcase
               end else begin
                  phase_in      = omv_pkg::PH_COUNT;
                  bytes_left_in = '0;
               end
            end
         end

         message_ok = !error_in && phase_in == omv_pkg::PH_COUNT && bytes_left_in == '0;

         if (end_of_message) begin
            phase_in       = omv_pkg::PH_PATH_FIRST;
            align_in       = '0;
            tag_count_in   = '0;
            sized_count_in = '0;
            tag_index_in   = '0;
            bytes_left_in  = '0;
            blob_shift_in  = '0;
            error_in       = 1'b0;
         end
      end
   end

endmodule

// ===== rtl/core/osc_message_validator_unit.sv =====
// Checks an OSC message that arrives one byte per item, with req_tlast on the final byte,
// and answers with one item per message: rsp_tdata[0] is 1 when the path, the type tag
// string and the argument sizes are well formed and the message ends on the last argument
// byte. One byte is taken every clock, but a last byte waits in the input register while a
// result is stalled in the result register; its result is registered there. Each byte passes an
// input register and the parse logic; the tags that occupy bytes are kept in a MAX_TYPES-entry
// tag ram, read one entry ahead of the argument that uses it.
module osc_message_validator_unit #(
   parameter int MAX_TYPES = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] data_byte
   input  logic       req_tlast,  // end_of_message
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata   // [0] message_valid, [7:1] zero
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       rsp_valid_ff;
   logic       rsp_ok_ff;
   logic       out_free;
   logic       step;
   logic       message_ok;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || step;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ok_ff};

   omv_parser #(
      .MAX_TYPES (MAX_TYPES)
   ) u_parser (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .data_byte      (in_byte_ff),
      .end_of_message (in_last_ff),
      .message_ok     (message_ok)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (step) begin
            in_valid_ff <= 1'b0;
         end
         if (step && in_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (step && in_last_ff) begin
         rsp_ok_ff <= message_ok;
      end
   end

endmodule

// ===== rtl/core/omv_checker.sv =====
module omv_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a fresh result follows an accepted last item
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast, 2))
      else $error("result without a preceding last item");

   // both sides come out of reset empty
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("channels not empty after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:1] == 7'd0)
      else $error("result padding bits not zero");

endmodule

bind osc_message_validator_unit omv_checker u_omv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== bench/osc_message_validator_checker.sv =====
module osc_message_validator_checker #(
   parameter int MAX_TYPES = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] data_byte
   input  logic       req_tlast,  // end_of_message
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,  // [0] message_valid, [7:1] zero
   output int         failures,
   output int         pending
);
   import omv_pkg::*;

   typedef enum logic [2:0] {
      ARG_UNKNOWN,
      ARG_NONE,
      ARG_FOUR,
      ARG_EIGHT,
      ARG_STR,
      ARG_BLOB
   } arg_kind_type;

   phase_type    phase;
   logic [1:0]   offset;
   arg_kind_type arg_kinds [MAX_TYPES];
   int unsigned  tags_seen;
   int unsigned  args_done;
   logic [31:0]  skip_left;
   logic [31:0]  blob_len;
   bit           broken;
   bit           verdicts_due [$];
   int           mismatch_count;

   function automatic arg_kind_type kind_of_tag(input logic [7:0] c);
      case (c)
         TAG_INT32, TAG_FLOAT, TAG_MIDI, TAG_CHAR:      return ARG_FOUR;
         TAG_INT64, TAG_DOUBLE, TAG_TIME:               return ARG_EIGHT;
         TAG_STRING, TAG_SYMBOL:                        return ARG_STR;
         TAG_BLOB:                                      return ARG_BLOB;
         TAG_TRUE, TAG_FALSE, TAG_NIL, TAG_IMPULSE:     return ARG_NONE;
         default:                                       return ARG_UNKNOWN;
      endcase
   endfunction

   // move on to the next tag that takes bytes, or to the end of the message
   function automatic void start_next_arg();
      arg_kind_type k;
      while (args_done < tags_seen && args_done < MAX_TYPES) begin
         k = arg_kinds[args_done];
         args_done++;
         case (k)
            ARG_FOUR: begin
               phase = PH_COUNT;
               skip_left = 32'd4;
               return;
            end
            ARG_EIGHT: begin
               phase = PH_COUNT;
               skip_left = 32'd8;
               return;
            end
            ARG_STR: begin
               phase = PH_STRING;
               return;
            end
            ARG_BLOB: begin
               phase = PH_BLOB_HEAD;
               blob_len = '0;
               return;
            end
            default: ;
         endcase
      end
      phase = PH_COUNT;
      skip_left = '0;
   endfunction

   function automatic void skip_padding();
      skip_left = {30'd0, 2'd0 - offset};
      phase = PH_COUNT;
      if (skip_left == 0) start_next_arg();
   endfunction

   function automatic void parse_byte(input logic [7:0] b);
      arg_kind_type k;
      case (phase)
         PH_PATH_FIRST: begin
            if (b != CHAR_SLASH) broken = 1'b1;
            else phase = PH_PATH;
         end
         PH_PATH: begin
            if (b == CHAR_NUL) phase = (offset == 0) ? PH_FMT_FIRST : PH_PATH_PAD;
            else if (b < PRINT_LOW || b > PRINT_HIGH || b == CHAR_HASH) broken = 1'b1;
         end
         PH_PATH_PAD: begin
            if (offset == 0) phase = PH_FMT_FIRST;
         end
         PH_FMT_FIRST: begin
            if (b != CHAR_COMMA) broken = 1'b1;
            else begin
               phase = PH_FMT;
               tags_seen = 0;
            end
         end
         PH_FMT: begin
            if (b == CHAR_NUL) begin
               args_done = 0;
               skip_padding();
            end else begin
               k = kind_of_tag(b);
               if (k == ARG_UNKNOWN || tags_seen >= MAX_TYPES) broken = 1'b1;
               else begin
                  arg_kinds[tags_seen] = k;
                  tags_seen++;
               end
            end
         end
         PH_STRING: begin
            if (b == CHAR_NUL) skip_padding();
         end
         PH_BLOB_HEAD: begin
            blob_len = {blob_len[23:0], b};
            if (offset == 0) begin
               // a size with the sign bit set cannot be skipped
               if (blob_len[31]) broken = 1'b1;
               else begin
                  skip_left = (blob_len + 32'd3) & ~32'd3;
                  phase = PH_COUNT;
                  if (skip_left == 0) start_next_arg();
               end
            end
         end
         default: begin
            if (skip_left == 0) broken = 1'b1;
            else begin
               skip_left--;
               if (skip_left == 0) start_next_arg();
            end
         end
      endcase
   endfunction

   function automatic void restart_message();
      phase = PH_PATH_FIRST;
      offset = '0;
      tags_seen = 0;
      args_done = 0;
      skip_left = '0;
      blob_len = '0;
      broken = 1'b0;
   endfunction

   always @(posedge clock) begin
      bit want;
      if (reset) begin
         restart_message();
         verdicts_due.delete();
         mismatch_count = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            offset = offset + 2'd1;
            if (!broken) parse_byte(req_tdata);
            if (req_tlast) begin
               verdicts_due.push_back(!broken && phase == PH_COUNT && skip_left == 0);
               restart_message();
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (verdicts_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result with no message pending: tdata %h", rsp_tdata);
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_tdata !== {7'd0, want}) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("message_valid: expected %0d, got tdata %h", want, rsp_tdata);
               end
            end
         end
      end
      failures <= mismatch_count;
      pending <= verdicts_due.size();
   end

endmodule

// ===== bench/tb_osc_message_validator_unit.sv =====
module tb_osc_message_validator_unit;
   import omv_pkg::*;

   localparam int MAX_TYPES = 32;
   localparam int CYCLE_LIMIT = 500000;
   localparam int BYTE_TARGET = 2000;
   localparam int MESSAGE_TARGET = 60;
   localparam logic [7:0] TAG_UNKNOWN = 8'h7A;

   typedef logic [7:0] byte_q [$];

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;

   int          failures;
   int          pending;
   int unsigned cycle_count = 0;
   byte_q       msg;
   bit          burst = 1'b0;
   int          forced_blob = -1;
   int unsigned bytes_sent = 0;
   int unsigned messages_sent = 0;
   int unsigned rsp_hold = 0;
   bit          rsp_steady = 1'b0;

   logic [7:0] tag_set [14] = '{TAG_INT32, TAG_FLOAT, TAG_MIDI, TAG_CHAR, TAG_INT64,
                                TAG_DOUBLE, TAG_TIME, TAG_STRING, TAG_SYMBOL, TAG_BLOB,
                                TAG_TRUE, TAG_FALSE, TAG_NIL, TAG_IMPULSE};

   osc_message_validator_unit #(.MAX_TYPES(MAX_TYPES)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   osc_message_validator_checker #(.MAX_TYPES(MAX_TYPES)) scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .failures   (failures),
      .pending    (pending)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result side: random stall after each item, with steady stretches now and then
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if ($urandom_range(0, 7) == 0) rsp_steady = !rsp_steady;
            rsp_hold = rsp_steady ? 0 : $urandom_range(0, 19);
         end else if (rsp_hold != 0) begin
            rsp_hold--;
         end
         rsp_tready <= (rsp_hold == 0);
      end
   end

   // messages start at offset zero, so padding follows the queue length
   function automatic void push_pad();
      while (msg.size() % 4 != 0) msg.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic logic [7:0] path_char();
      logic [7:0] c;
      do c = 8'($urandom_range(PRINT_LOW, PRINT_HIGH)); while (c == CHAR_HASH);
      return c;
   endfunction

   function automatic byte_q random_tags(input int unsigned count);
      byte_q q;
      repeat (count) q.push_back(tag_set[$urandom_range(0, 13)]);
      return q;
   endfunction

   function automatic int unsigned pick_blob_size();
      if (forced_blob >= 0) return forced_blob;
      if ($urandom_range(0, 19) == 0) return $urandom_range(100, 400);
      return $urandom_range(0, 13);
   endfunction

   function automatic void build_message(input int unsigned path_len, input byte_q tags,
                                         input bit neg_blob);
      logic [31:0] size;
      msg.delete();
      msg.push_back(CHAR_SLASH);
      repeat (path_len) msg.push_back(path_char());
      msg.push_back(CHAR_NUL);
      push_pad();
      msg.push_back(CHAR_COMMA);
      foreach (tags[i]) msg.push_back(tags[i]);
      msg.push_back(CHAR_NUL);
      push_pad();
      foreach (tags[i]) begin
         case (tags[i])
            TAG_INT32, TAG_FLOAT, TAG_MIDI, TAG_CHAR: begin
               repeat (4) msg.push_back(8'($urandom_range(0, 255)));
            end
            TAG_INT64, TAG_DOUBLE, TAG_TIME: begin
               repeat (8) msg.push_back(8'($urandom_range(0, 255)));
            end
            TAG_STRING, TAG_SYMBOL: begin
               repeat ($urandom_range(0, 9)) msg.push_back(8'($urandom_range(1, 255)));
               msg.push_back(CHAR_NUL);
               push_pad();
            end
            TAG_BLOB: begin
               size = neg_blob ? {1'b1, 31'($urandom)} : pick_blob_size();
               for (int s = 24; s >= 0; s -= 8) msg.push_back(size[s +: 8]);
               if (neg_blob) begin
                  repeat ($urandom_range(0, 6)) msg.push_back(8'($urandom_range(0, 255)));
                  return;
               end
               repeat (size) msg.push_back(8'($urandom_range(0, 255)));
               push_pad();
            end
            default: ;
         endcase
      end
   endfunction

   task automatic run_message();
      int unsigned gap;
      foreach (msg[i]) begin
         gap = burst ? 0 : $urandom_range(0, 19);
         repeat (gap) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= msg[i];
         req_tlast <= (i == msg.size() - 1);
         do @(posedge clock); while (!req_tready);
      end
      bytes_sent += msg.size();
      messages_sent++;
   endtask

   initial begin
      byte_q       tags;
      byte_q       no_tags;
      int unsigned pick;
      int unsigned n_tags;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // early end inside the path, and a lone non-slash byte
      msg = {CHAR_SLASH};
      run_message();
      msg = {8'hFF};
      run_message();

      // shortest well-formed message
      build_message(0, no_tags, 1'b0);
      run_message();

      // printable extremes, then bytes the path must reject
      build_message(3, no_tags, 1'b0);
      msg[1] = PRINT_LOW;
      msg[2] = PRINT_HIGH;
      run_message();
      foreach (tag_set[i]) begin
         if (i < 6) begin
            build_message(3, no_tags, 1'b0);
            case (i)
               0: msg[2] = 8'h80;
               1: msg[2] = 8'hFF;
               2: msg[2] = CHAR_HASH;
               3: msg[2] = 8'h20;
               4: msg[2] = 8'h7F;
               default: msg[2] = 8'h01;
            endcase
            run_message();
         end
      end

      // every tag once
      tags.delete();
      foreach (tag_set[i]) tags.push_back(tag_set[i]);
      build_message(5, tags, 1'b0);
      run_message();

      // unknown tag, missing comma
      build_message(1, {TAG_INT32, TAG_UNKNOWN}, 1'b0);
      run_message();
      build_message(0, no_tags, 1'b0);
      msg[4] = CHAR_SLASH;
      run_message();

      // tag table full, then one tag too many
      tags.delete();
      repeat (MAX_TYPES) tags.push_back(TAG_INT32);
      build_message(2, tags, 1'b0);
      run_message();
      tags.push_back(TAG_INT32);
      build_message(2, tags, 1'b0);
      run_message();

      // empty blob, blob with sign bit set
      forced_blob = 0;
      build_message(2, {TAG_BLOB, TAG_INT32}, 1'b0);
      run_message();
      forced_blob = -1;
      build_message(2, {TAG_BLOB}, 1'b1);
      run_message();

      // extra byte after the last argument, and a cut inside one
      build_message(4, {TAG_INT64}, 1'b0);
      msg.push_back(8'($urandom_range(0, 255)));
      run_message();
      build_message(4, {TAG_INT64}, 1'b0);
      void'(msg.pop_back());
      void'(msg.pop_back());
      run_message();

      while (bytes_sent < BYTE_TARGET || messages_sent < MESSAGE_TARGET) begin
         burst = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 15);
         n_tags = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_TYPES - 2, MAX_TYPES + 2)
                                              : $urandom_range(0, 6);
         tags = random_tags(n_tags);
         if (pick == 15) tags.push_back(TAG_BLOB);
         build_message($urandom_range(0, 9), tags, pick == 15);
         case (pick)
            0: begin
               msg.delete();
               repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom_range(0, 255)));
            end
            1, 2: begin
               repeat ($urandom_range(1, msg.size() - 1)) void'(msg.pop_back());
            end
            3: begin
               repeat ($urandom_range(1, 5)) msg.push_back(8'($urandom_range(0, 255)));
            end
            4: begin
               msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
            end
            5: begin
               case ($urandom_range(0, 2))
                  0: msg.insert(1, 8'($urandom_range(8'h80, 8'hFF)));
                  1: msg.insert(1, 8'($urandom_range(8'h01, 8'h20)));
                  default: msg.insert(1, CHAR_HASH);
               endcase
            end
            default: ;
         endcase
         run_message();
      end
      req_tvalid <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
